// ===== hdl/lwsv_pkg.sv =====
// ----------------------------------------------------------------------------
// Lag window spectral variance: shared definitions
// Widths, register indexes and the raised cosine table of the block.
// ----------------------------------------------------------------------------
package lwsv_pkg;

	localparam int NUM_COMPONENTS = 4;
	localparam int SAMPLE_W       = 16;
	localparam int ROW_W          = NUM_COMPONENTS * SAMPLE_W;
	localparam int VALUE_W        = 48;
	localparam int WLEN_W         = 11;
	localparam int WEIGHT_W       = 16;
	localparam int ACC_W          = 64;
	localparam int IDX_W          = 2;
	localparam int ENTRY_W        = 2 * IDX_W;
	localparam int MAX_ROWS_DEF   = 1024;
	localparam int WLEN_RESET     = 32;

	typedef enum logic {
		CFG_WINDOW_LEN   = 1'b0,
		CFG_WINDOW_SHAPE = 1'b1
	} cfg_index_t;

	typedef enum logic {
		SHAPE_BARTLETT = 1'b0,
		SHAPE_TUKEY    = 1'b1
	} shape_t;

	// Raised cosine (1 + cos(pi*k/32)) / 2 in Q1.15.
	function automatic logic [WEIGHT_W-1:0] hann(input logic [5:0] k);
		logic [WEIGHT_W-1:0] v;
		unique case (k)
			6'd0:  v = 16'd32768;
			6'd1:  v = 16'd32689;
			6'd2:  v = 16'd32453;
			6'd3:  v = 16'd32063;
			6'd4:  v = 16'd31521;
			6'd5:  v = 16'd30833;
			6'd6:  v = 16'd30007;
			6'd7:  v = 16'd29049;
			6'd8:  v = 16'd27969;
			6'd9:  v = 16'd26778;
			6'd10: v = 16'd25486;
			6'd11: v = 16'd24107;
			6'd12: v = 16'd22654;
			6'd13: v = 16'd21140;
			6'd14: v = 16'd19580;
			6'd15: v = 16'd17990;
			6'd16: v = 16'd16384;
			6'd17: v = 16'd14778;
			6'd18: v = 16'd13188;
			6'd19: v = 16'd11628;
			6'd20: v = 16'd10114;
			6'd21: v = 16'd8661;
			6'd22: v = 16'd7282;
			6'd23: v = 16'd5990;
			6'd24: v = 16'd4799;
			6'd25: v = 16'd3719;
			6'd26: v = 16'd2761;
			6'd27: v = 16'd1935;
			6'd28: v = 16'd1247;
			6'd29: v = 16'd705;
			6'd30: v = 16'd315;
			6'd31: v = 16'd79;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/lag_window_spectral_variance.sv =====
// ----------------------------------------------------------------------------
// Lag window spectral variance estimator
// Stores a chain of rows, then gives the lag weighted cross product matrix.
//
// Channel   Signals                                     Direction
// rows      start, busy, sample_0..3, last_row          in
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   in
// entries   entry_valid, entry_value/row/col, last_entry out
//
// A row that is not last is written to the row store; the block stays idle.
// A last row starts the lag sum: per lag, weight setup around a serial
// divider, then a read and a multiply of the 16 entries for each row pair
// i, i+s, then weighting of the 16 entries; each of the 16 entries is then
// divided by the row count. The weights and that division share the divider.
// Reset restores control state and window settings; the receiver cannot stall.
// ----------------------------------------------------------------------------
module lag_window_spectral_variance #(
	parameter int MAX_ROWS = lwsv_pkg::MAX_ROWS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [lwsv_pkg::SAMPLE_W-1:0]   sample_0,
	input  logic signed [lwsv_pkg::SAMPLE_W-1:0]   sample_1,
	input  logic signed [lwsv_pkg::SAMPLE_W-1:0]   sample_2,
	input  logic signed [lwsv_pkg::SAMPLE_W-1:0]   sample_3,
	input  logic                                   last_row,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic                                   cfg_index,
	input  logic [lwsv_pkg::WLEN_W-1:0]            cfg_data,
	output logic                                   entry_valid,
	output logic signed [lwsv_pkg::VALUE_W-1:0]    entry_value,
	output logic [lwsv_pkg::IDX_W-1:0]             entry_row,
	output logic [lwsv_pkg::IDX_W-1:0]             entry_col,
	output logic                                   last_entry
);
	import lwsv_pkg::*;

	localparam int CW  = $clog2(MAX_ROWS + 1);
	localparam int AW  = $clog2(MAX_ROWS);
	localparam int DW  = (CW > WLEN_W) ? CW : WLEN_W;
	localparam int LW  = CW + 33;
	localparam int PW  = LW + WEIGHT_W + 1;
	localparam int NE  = NUM_COMPONENTS * NUM_COMPONENTS;
	localparam int DCW = $clog2(ACC_W);

	typedef enum logic [3:0] {
		S_IDLE, S_LAG, S_DIV, S_WCALC, S_RD, S_MUL, S_DRAIN, S_WGT, S_WDRAIN,
		S_FIN, S_OUT
	} state_t;

	state_t                    state_q;
	logic [WLEN_W-1:0]         wlen_q;
	logic                      shape_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             n_q;
	logic [WLEN_W-1:0]         b_q;
	logic [WLEN_W-1:0]         s_q;
	logic [CW-1:0]             i_q;
	logic [ENTRY_W-1:0]        e_q;
	logic [WEIGHT_W-1:0]       w_q;
	logic                      fin_q;
	logic [ACC_W-1:0]          dv_num_q;
	logic [DW-1:0]             dv_rem_q;
	logic [DW-1:0]             dv_den_q;
	logic [DCW-1:0]            dv_cnt_q;

	logic [ROW_W-1:0]          row_mem [MAX_ROWS];
	logic [ROW_W-1:0]          rd_a_q;
	logic [ROW_W-1:0]          rd_b_q;
	logic [AW-1:0]             ra;
	logic [AW-1:0]             rb;
	logic [CW:0]               ib_sum;

	logic signed [LW-1:0]      lagm [NE];
	logic signed [ACC_W-1:0]   acc [NE];
	logic signed [32:0]        p_s1;
	logic [ENTRY_W-1:0]        e_s1;
	logic                      pv_s1;
	logic signed [PW-1:0]      wp_s1;
	logic                      wv_s1;
	logic                      acc_clr;

	logic                      accept;
	logic [CW-1:0]             cnt_next;
	logic [WLEN_W-1:0]         wl_eff;
	logic [WLEN_W-1:0]         b_next;

	logic [DW:0]               dv_try;
	logic                      dv_ge;
	logic [DW-1:0]             dv_rem_next;

	logic [IDX_W-1:0]          ea;
	logic [IDX_W-1:0]          ec;
	logic signed [SAMPLE_W-1:0] xa_a;
	logic signed [SAMPLE_W-1:0] xa_c;
	logic signed [SAMPLE_W-1:0] xb_a;
	logic signed [SAMPLE_W-1:0] xb_c;
	logic signed [32:0]        prod_sum;

	logic [4:0]                hk;
	logic [WEIGHT_W-1:0]       hk0;
	logic [WEIGHT_W-1:0]       hk1;
	logic [32:0]               hinterp;
	logic [WEIGHT_W-1:0]       w_calc;

	logic                      wp_neg;
	logic [PW-1:0]             wp_mag;
	logic [PW-1:0]             wp_rnd;
	logic signed [ACC_W-1:0]   wp_add;

	logic signed [ACC_W-1:0]   acc_e;
	logic [ACC_W-1:0]          acc_mag;
	logic                      sat_hi;
	logic                      sat_lo;
	logic [VALUE_W-1:0]        q_val;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	assign cnt_next = (cnt_q < CW'(MAX_ROWS)) ? cnt_q + 1'b1 : cnt_q;
	assign wl_eff   = (wlen_q == '0) ? WLEN_W'(1) : wlen_q;
	assign b_next   = ({{(DW-WLEN_W){1'b0}}, wl_eff} > {{(DW-CW){1'b0}}, cnt_next}) ?
		WLEN_W'(cnt_next) : wl_eff;

	assign ib_sum = {1'b0, i_q} + (CW+1)'(s_q);
	assign ra     = i_q[AW-1:0];
	assign rb     = ib_sum[AW-1:0];

	always_ff @(posedge clk) begin
		if (accept && (cnt_q < CW'(MAX_ROWS))) begin
			row_mem[cnt_q[AW-1:0]] <= {sample_3, sample_2, sample_1, sample_0};
		end
		rd_a_q <= row_mem[ra];
		rd_b_q <= row_mem[rb];
	end

	assign dv_try      = {dv_rem_q, dv_num_q[ACC_W-1]};
	assign dv_ge       = (dv_try >= {1'b0, dv_den_q});
	assign dv_rem_next = dv_ge ? DW'(dv_try - {1'b0, dv_den_q}) : DW'(dv_try);

	assign ea   = e_q[ENTRY_W-1:IDX_W];
	assign ec   = e_q[IDX_W-1:0];
	assign xa_a = rd_a_q[SAMPLE_W*ea +: SAMPLE_W];
	assign xa_c = rd_a_q[SAMPLE_W*ec +: SAMPLE_W];
	assign xb_a = rd_b_q[SAMPLE_W*ea +: SAMPLE_W];
	assign xb_c = rd_b_q[SAMPLE_W*ec +: SAMPLE_W];
	assign prod_sum = 33'(xa_a * xb_c) + ((s_q != '0) ? 33'(xa_c * xb_a) : 33'sd0);

	assign hk      = dv_num_q[20:16];
	assign hk0     = hann({1'b0, hk});
	assign hk1     = hann({1'b0, hk} + 6'd1);
	assign hinterp = 33'((hk0 - hk1) * dv_num_q[15:0]) + 33'd32768;
	assign w_calc  = (shape_q == SHAPE_BARTLETT) ? dv_num_q[WEIGHT_W-1:0] :
		hk0 - hinterp[31:16];

	assign wp_neg = wp_s1[PW-1];
	assign wp_mag = wp_neg ? PW'(-wp_s1) : PW'(wp_s1);
	assign wp_rnd = (wp_mag + PW'(16384)) >> 15;
	assign wp_add = wp_neg ? -ACC_W'(signed'({1'b0, wp_rnd})) :
		ACC_W'(signed'({1'b0, wp_rnd}));

	assign acc_e   = acc[e_q];
	assign acc_mag = acc_e[ACC_W-1] ? ACC_W'(-acc_e) : ACC_W'(acc_e);
	assign sat_hi  = |dv_num_q[ACC_W-1:VALUE_W-1];
	assign sat_lo  = (|dv_num_q[ACC_W-1:VALUE_W]) ||
		(dv_num_q[VALUE_W-1] && (|dv_num_q[VALUE_W-2:0]));
	always_comb begin
		if (acc_e[ACC_W-1]) begin
			q_val = sat_lo ? {1'b1, {(VALUE_W-1){1'b0}}} : VALUE_W'(-dv_num_q);
		end else begin
			q_val = sat_hi ? {1'b0, {(VALUE_W-1){1'b1}}} : dv_num_q[VALUE_W-1:0];
		end
	end

	assign acc_clr = accept && last_row;

	always_ff @(posedge clk) begin
		p_s1  <= prod_sum;
		wp_s1 <= PW'(lagm[e_q]) * PW'(signed'({1'b0, w_q}));
		e_s1  <= e_q;
		if (state_q == S_WCALC) begin
			for (int k = 0; k < NE; k++) begin
				lagm[k] <= '0;
			end
		end else if (pv_s1) begin
			lagm[e_s1] <= lagm[e_s1] + LW'(p_s1);
		end
		if (acc_clr) begin
			for (int k = 0; k < NE; k++) begin
				acc[k] <= '0;
			end
		end else if (wv_s1) begin
			acc[e_s1] <= acc[e_s1] + wp_add;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wlen_q      <= WLEN_W'(WLEN_RESET);
			shape_q     <= SHAPE_BARTLETT;
			cnt_q       <= '0;
			n_q         <= '0;
			b_q         <= '0;
			s_q         <= '0;
			i_q         <= '0;
			e_q         <= '0;
			w_q         <= '0;
			fin_q       <= 1'b0;
			dv_num_q    <= '0;
			dv_rem_q    <= '0;
			dv_den_q    <= '0;
			dv_cnt_q    <= '0;
			pv_s1       <= 1'b0;
			wv_s1       <= 1'b0;
			entry_valid <= 1'b0;
			entry_value <= '0;
			entry_row   <= '0;
			entry_col   <= '0;
			last_entry  <= 1'b0;
		end else begin
			pv_s1       <= (state_q == S_MUL);
			wv_s1       <= (state_q == S_WGT);
			entry_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_WINDOW_LEN:   wlen_q  <= cfg_data;
					CFG_WINDOW_SHAPE: shape_q <= cfg_data[0];
					default:          wlen_q  <= wlen_q;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (last_row) begin
							n_q     <= cnt_next;
							b_q     <= b_next;
							s_q     <= '0;
							cnt_q   <= '0;
							state_q <= S_LAG;
						end else begin
							cnt_q <= cnt_next;
						end
					end
				end
				S_LAG: begin
					fin_q    <= 1'b0;
					dv_rem_q <= '0;
					dv_cnt_q <= '0;
					dv_den_q <= DW'(b_q);
					if (shape_q == SHAPE_BARTLETT) begin
						dv_num_q <= (ACC_W'(b_q - s_q) << 15) + ACC_W'(b_q >> 1);
					end else begin
						dv_num_q <= ACC_W'(s_q) << 21;
					end
					state_q  <= S_DIV;
				end
				S_DIV: begin
					dv_num_q <= {dv_num_q[ACC_W-2:0], dv_ge};
					dv_rem_q <= dv_rem_next;
					dv_cnt_q <= dv_cnt_q + 1'b1;
					if (dv_cnt_q == DCW'(ACC_W - 1)) begin
						state_q <= fin_q ? S_OUT : S_WCALC;
					end
				end
				S_WCALC: begin
					w_q     <= w_calc;
					i_q     <= '0;
					e_q     <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					e_q <= e_q + 1'b1;
					if (e_q == ENTRY_W'(NE - 1)) begin
						if ((ib_sum + 1'b1) < {1'b0, n_q}) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_RD;
						end else begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					e_q     <= '0;
					state_q <= S_WGT;
				end
				S_WGT: begin
					e_q <= e_q + 1'b1;
					if (e_q == ENTRY_W'(NE - 1)) begin
						state_q <= S_WDRAIN;
					end
				end
				S_WDRAIN: begin
					e_q <= '0;
					if ((s_q + 1'b1) < b_q) begin
						s_q     <= s_q + 1'b1;
						state_q <= S_LAG;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					fin_q    <= 1'b1;
					dv_rem_q <= '0;
					dv_cnt_q <= '0;
					dv_den_q <= DW'(n_q);
					dv_num_q <= acc_mag + ACC_W'(n_q >> 1);
					state_q  <= S_DIV;
				end
				S_OUT: begin
					entry_valid <= 1'b1;
					entry_value <= q_val;
					entry_row   <= ea;
					entry_col   <= ec;
					last_entry  <= (e_q == ENTRY_W'(NE - 1));
					e_q         <= e_q + 1'b1;
					state_q     <= (e_q == ENTRY_W'(NE - 1)) ? S_IDLE : S_FIN;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== bench/tb_lag_window_spectral_variance.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lag window spectral variance estimator: testbench
// Sends chains of sample rows under several window settings. A scoreboard
// computes the windowed lag sum of each chain and checks every entry beat.
// ----------------------------------------------------------------------------
module tb_lag_window_spectral_variance;
	import lwsv_pkg::*;

	localparam int ROW_LIMIT  = 1024;
	localparam int WDOG_LIMIT = 400000;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic               last;
	} entry_t;

	class variance_scoreboard;
		int     rows[ROW_LIMIT][NUM_COMPONENTS];
		int     row_count;
		int     win_len;
		shape_t win_shape;
		entry_t pending[$];
		int     mismatches;
		int     hann_tab[33] = '{
			32768, 32689, 32453, 32063, 31521, 30833, 30007, 29049,
			27969, 26778, 25486, 24107, 22654, 21140, 19580, 17990,
			16384, 14778, 13188, 11628, 10114, 8661, 7282, 5990,
			4799, 3719, 2761, 1935, 1247, 705, 315, 79, 0};

		function new();
			row_count  = 0;
			win_len    = WLEN_RESET;
			win_shape  = SHAPE_BARTLETT;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [WLEN_W-1:0] data);
			if (idx == CFG_WINDOW_LEN) begin
				win_len = int'(data);
			end else begin
				win_shape = shape_t'(data[0]);
			end
		endfunction

		function longint round_div(longint v, longint d);
			longint m;
			longint r;
			m = (v < 0) ? -v : v;
			r = (m + d / 2) / d;
			return (v < 0) ? -r : r;
		endfunction

		function longint lag_weight(int s, int b);
			longint ph;
			longint f;
			longint diff;
			int     k;
			if (win_shape == SHAPE_BARTLETT) begin
				return ((longint'(b - s) << 15) + b / 2) / b;
			end
			ph   = (longint'(s) << 21) / b;
			k    = int'((ph >> 16) & 31);
			f    = ph & 65535;
			diff = hann_tab[k] - hann_tab[k + 1];
			return hann_tab[k] - ((diff * f + 32768) >> 16);
		endfunction

		function void note_row(int x[NUM_COMPONENTS], logic lst);
			longint acc[NUM_COMPONENTS][NUM_COMPONENTS];
			longint lag[NUM_COMPONENTS][NUM_COMPONENTS];
			longint w;
			longint t;
			longint q;
			int     n;
			int     b;
			entry_t e;
			if (row_count < ROW_LIMIT) begin
				for (int a = 0; a < NUM_COMPONENTS; a++) rows[row_count][a] = x[a];
				row_count++;
			end
			if (!lst) return;
			n = row_count;
			b = (win_len == 0) ? 1 : win_len;
			if (b > n) b = n;
			foreach (acc[a, c]) acc[a][c] = 0;
			for (int s = 0; s < b; s++) begin
				w = lag_weight(s, b);
				foreach (lag[a, c]) lag[a][c] = 0;
				for (int i = 0; i + s < n; i++)
					foreach (lag[a, c])
						lag[a][c] += longint'(rows[i][a]) * longint'(rows[i + s][c]);
				foreach (acc[a, c]) begin
					t = lag[a][c] + ((s != 0) ? lag[c][a] : 0);
					acc[a][c] += round_div(t * w, 32768);
				end
			end
			for (int a = 0; a < NUM_COMPONENTS; a++)
				for (int c = 0; c < NUM_COMPONENTS; c++) begin
					q = round_div(acc[a][c], n);
					if (q > 64'sd140737488355327) q = 64'sd140737488355327;
					if (q < -64'sd140737488355328) q = -64'sd140737488355328;
					e.value = q[VALUE_W-1:0];
					e.row   = IDX_W'(a);
					e.col   = IDX_W'(c);
					e.last  = (a == NUM_COMPONENTS - 1) && (c == NUM_COMPONENTS - 1);
					pending.push_back(e);
				end
			row_count = 0;
		endfunction

		function void check_entry(entry_t got);
			entry_t exp_e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected entry beat: value %0d row %0d col %0d",
						$signed(got.value), got.row, got.col);
				return;
			end
			exp_e = pending.pop_front();
			if (got !== exp_e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Entry mismatch: expected %0d (%0d,%0d,%0b) got %0d (%0d,%0d,%0b)",
						$signed(exp_e.value), exp_e.row, exp_e.col, exp_e.last,
						$signed(got.value), got.row, got.col, got.last);
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic signed [SAMPLE_W-1:0] sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0;
	logic                       last_row = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	cfg_index_t                 cfg_index = CFG_WINDOW_LEN;
	logic [WLEN_W-1:0]          cfg_data = '0;
	logic                       entry_valid;
	logic signed [VALUE_W-1:0]  entry_value;
	logic [IDX_W-1:0]           entry_row, entry_col;
	logic                       last_entry;

	variance_scoreboard sb = new();
	int                 idle_pct;
	int                 stall_cycles = 0;

	always #5 clk = ~clk;

	lag_window_spectral_variance dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
		.last_row(last_row), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .entry_valid(entry_valid),
		.entry_value(entry_value), .entry_row(entry_row), .entry_col(entry_col),
		.last_entry(last_entry)
	);

	always @(posedge clk) begin
		entry_t got;
		if (arst_n && entry_valid) begin
			got.value = entry_value;
			got.row   = entry_row;
			got.col   = entry_col;
			got.last  = last_entry;
			sb.check_entry(got);
		end
		if (arst_n && ((start && !busy) || entry_valid || (cfg_valid && cfg_ready))) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WDOG_LIMIT) begin
			$display("FAIL lag_window_spectral_variance");
			$finish;
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_row(logic [SAMPLE_W-1:0] x0, x1, x2, x3, logic lst);
		int xs[NUM_COMPONENTS];
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start    = 1'b1;
		sample_0 = x0;
		sample_1 = x1;
		sample_2 = x2;
		sample_3 = x3;
		last_row = lst;
		do @(posedge clk); while (busy);
		xs = '{$signed(x0), $signed(x1), $signed(x2), $signed(x3)};
		sb.note_row(xs, lst);
		@(negedge clk);
	endtask

	task automatic send_chain(int len);
		for (int i = 0; i < len; i++)
			send_row(pick_sample(), pick_sample(), pick_sample(), pick_sample(), i == len - 1);
	endtask

	// The block is written to only when it has drained every entry beat.
	task automatic write_reg(cfg_index_t idx, logic [WLEN_W-1:0] data);
		start = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_setting();
		logic [WLEN_W-1:0] len;
		case ($urandom_range(7))
			0: len = 0;
			1: len = 1;
			2: len = 1024;
			3: len = 2047;
			4: len = WLEN_W'($urandom);
			default: len = WLEN_W'($urandom_range(2, 16));
		endcase
		write_reg(CFG_WINDOW_LEN, len);
		write_reg(CFG_WINDOW_SHAPE, WLEN_W'($urandom_range(1)));
	endtask

	task automatic random_phase(int rows_total);
		int sent;
		int len;
		sent = 0;
		while (sent < rows_total) begin
			if ($urandom_range(3) == 0) random_setting();
			len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
			send_chain(len);
			sent += len;
		end
	endtask

	initial begin
		idle_pct = 27;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset window, single row with every extreme.
		send_row(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1);
		send_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
		send_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
		write_reg(CFG_WINDOW_LEN, 1024);
		send_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
		send_row(16'h8000, 16'h0001, 16'hffff, 16'h0000, 1'b0);
		send_row(16'h7fff, 16'h8000, 16'h5555, 16'haaaa, 1'b1);
		write_reg(CFG_WINDOW_LEN, 0);
		send_chain(3);
		write_reg(CFG_WINDOW_SHAPE, WLEN_W'(SHAPE_TUKEY));
		write_reg(CFG_WINDOW_LEN, 2047);
		send_chain(6);
		write_reg(CFG_WINDOW_LEN, 3);
		send_chain(8);

		random_phase(130);
		idle_pct = 80;
		random_phase(130);
		idle_pct = 0;
		random_phase(130);

		start = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("PASS lag_window_spectral_variance");
		end else begin
			$display("FAIL lag_window_spectral_variance");
		end
		$finish;
	end
endmodule
